### rtl/core/teq_pkg.sv
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared sizes, request and status codes, sequencer states and the command
// and read-back types that pass between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned MAX_FIRES = 64;

  localparam int unsigned SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FIRE_W   = $clog2(MAX_FIRES + 1);
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_NOP      = 2'd3
  } teq_req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_ZERO_PERIOD = 2'd1,
    STAT_CAP         = 2'd2
  } teq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT,
    ST_SCAN,
    ST_PICK
  } teq_state_e;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_LOAD,
    SOP_REQUEUE,
    SOP_DISARM,
    SOP_RETIRE,
    SOP_DROP
  } teq_slot_op_e;

  typedef struct packed {
    teq_slot_op_e          op;
    logic [SLOT_W-1:0]     idx;
    logic [TIME_W-1:0]     exp_time;
    logic [PERIOD_W-1:0]   period;
    logic                  once;
  } teq_slot_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]     scan_time;
    logic                  scan_queued;
    logic                  pick_armed;
    logic                  pick_once;
    logic [PERIOD_W-1:0]   pick_period;
    logic                  ref_queued;
  } teq_slot_rd_t;

endpackage

### rtl/core/teq_if.sv
// ----------------------------------------------------------------------------
// Timer expiry queue channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface teq_req_if;
  logic                          valid;
  logic                          ready;
  logic [teq_pkg::REQ_W-1:0]     req_type;
  logic [teq_pkg::ID_W-1:0]      slot_id;
  logic [teq_pkg::PERIOD_W-1:0]  period_us;
  logic                          single_shot;
  logic [teq_pkg::TIME_W-1:0]    now_us;

  modport source (output valid, req_type, slot_id, period_us, single_shot, now_us,
                  input ready);
  modport sink   (input valid, req_type, slot_id, period_us, single_shot, now_us,
                  output ready);
endinterface

interface teq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          fired;
  logic [teq_pkg::ID_W-1:0]      fired_slot;
  logic [teq_pkg::TIME_W-1:0]    fire_time_us;
  logic [teq_pkg::STAT_W-1:0]    status;
  logic                          last;

  modport source (output valid, fired, fired_slot, fire_time_us, status, last,
                  input ready);
  modport sink   (input valid, fired, fired_slot, fire_time_us, status, last,
                  output ready);
endinterface

### rtl/core/teq_alu.sv
// ----------------------------------------------------------------------------
// Timer expiry queue arithmetic unit
// Shared time comparators and the expiry adder used by the sequencer steps.
// ----------------------------------------------------------------------------
module teq_alu (
  input  logic [teq_pkg::TIME_W-1:0] cmp_a_i,
  input  logic [teq_pkg::TIME_W-1:0] cmp_b_i,
  input  logic [teq_pkg::TIME_W-1:0] cmp_c_i,
  input  logic [teq_pkg::TIME_W-1:0] add_a_i,
  input  logic [teq_pkg::TIME_W-1:0] add_b_i,
  output logic                       a_le_b_o,
  output logic                       a_lt_c_o,
  output logic [teq_pkg::TIME_W-1:0] sum_o
);

  // Time sums wrap modulo the time width.
  assign a_le_b_o = (cmp_a_i <= cmp_b_i);
  assign a_lt_c_o = (cmp_a_i <  cmp_c_i);
  assign sum_o    = add_a_i + add_b_i;

endmodule

### rtl/core/teq_slots.sv
// ----------------------------------------------------------------------------
// Timer expiry queue slot store
// Per-slot expiry, period and one-shot payload plus armed and queued flags.
// ----------------------------------------------------------------------------
module teq_slots (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  teq_pkg::teq_slot_cmd_t      cmd_i,
  input  logic [teq_pkg::SLOT_W-1:0]  scan_idx_i,
  input  logic [teq_pkg::SLOT_W-1:0]  pick_idx_i,
  input  logic [teq_pkg::SLOT_W-1:0]  ref_idx_i,
  output teq_pkg::teq_slot_rd_t       rd_o
);

  logic [teq_pkg::TIME_W-1:0]   expiry_q [teq_pkg::SLOTS];
  logic [teq_pkg::PERIOD_W-1:0] period_q [teq_pkg::SLOTS];
  logic [teq_pkg::SLOTS-1:0]    once_q;
  logic [teq_pkg::SLOTS-1:0]    armed_q;
  logic [teq_pkg::SLOTS-1:0]    queued_q;

  // Payload is only read for queued slots, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == teq_pkg::SOP_LOAD) begin
      expiry_q[cmd_i.idx] <= cmd_i.exp_time;
      period_q[cmd_i.idx] <= cmd_i.period;
      once_q[cmd_i.idx]   <= cmd_i.once;
    end else if (cmd_i.op == teq_pkg::SOP_REQUEUE) begin
      expiry_q[cmd_i.idx] <= cmd_i.exp_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= '0;
      queued_q <= '0;
    end else begin
      case (cmd_i.op)
        teq_pkg::SOP_LOAD: begin
          armed_q[cmd_i.idx]  <= 1'b1;
          queued_q[cmd_i.idx] <= 1'b1;
        end
        teq_pkg::SOP_DISARM: begin
          armed_q[cmd_i.idx] <= 1'b0;
        end
        teq_pkg::SOP_RETIRE: begin
          armed_q[cmd_i.idx]  <= 1'b0;
          queued_q[cmd_i.idx] <= 1'b0;
        end
        teq_pkg::SOP_DROP: begin
          queued_q[cmd_i.idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_o.scan_time   = expiry_q[scan_idx_i];
  assign rd_o.scan_queued = queued_q[scan_idx_i];
  assign rd_o.pick_armed  = armed_q[pick_idx_i];
  assign rd_o.pick_once   = once_q[pick_idx_i];
  assign rd_o.pick_period = period_q[pick_idx_i];
  assign rd_o.ref_queued  = queued_q[ref_idx_i];

  // An armed slot is always queued.
  a_armed_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & ~queued_q) == '0)
    else $error("armed slot is not queued");

  // Only disarmed slots leave silently.
  a_drop_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == teq_pkg::SOP_DROP) |-> !armed_q[cmd_i.idx])
    else $error("armed slot dropped without firing");

  // Commands only address existing slots.
  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != teq_pkg::SOP_NONE) |-> (32'(cmd_i.idx) < 32'(teq_pkg::SLOTS)))
    else $error("slot command out of range");

endmodule

### rtl/core/timer_expiry_queue_core.sv
// ----------------------------------------------------------------------------
// Timer expiry queue core
// Fixed set of one-shot and periodic timer slots; ticks fire due slots in
// order of expiry through a sequencer that scans the slot store one slot a
// cycle using a shared compare and add unit.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Item carries
//   req_i    in         valid/ready    req_type, slot_id, period_us,
//                                      single_shot, now_us
//   rsp_o    out        valid/ready    fired, fired_slot, fire_time_us,
//                                      status, last
//
// A register, cancel or no-operation request passes from acceptance through
// the execute and result states, and its result is loaded into the output
// register once that register is free. A tick runs one pass per firing and
// per cancelled slot that leaves, plus a closing pass; each pass is one scan
// of the slot store (one compare per slot) plus one decision in the pick state.
// The request channel is ready only while the sequencer is idle; a result
// waiting in the output register does not hold off the next request.
// A stalled response channel pauses the tick at the next firing to report.
// Reset is asynchronous and active low and clears all flags; slot payload
// is not reset.
// ----------------------------------------------------------------------------
module timer_expiry_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  teq_req_if.sink   req_i,
  teq_rsp_if.source rsp_o
);

  teq_pkg::teq_state_e state_q, state_d;

  // Latched request.
  logic [teq_pkg::REQ_W-1:0]    req_type_q, req_type_d;
  logic [teq_pkg::ID_W-1:0]     slot_q, slot_d;
  logic [teq_pkg::PERIOD_W-1:0] period_q, period_d;
  logic                         once_q, once_d;
  logic [teq_pkg::TIME_W-1:0]   now_q, now_d;

  // Search state.
  logic [teq_pkg::SLOT_W-1:0]   scan_q, scan_d;
  logic                         found_q, found_d;
  logic [teq_pkg::SLOT_W-1:0]   best_idx_q, best_idx_d;
  logic [teq_pkg::TIME_W-1:0]   best_time_q, best_time_d;
  logic [teq_pkg::FIRE_W-1:0]   fires_q, fires_d;

  // A firing is held back until the next search tells whether it is the last.
  logic                         held_q, held_d;
  logic [teq_pkg::SLOT_W-1:0]   held_slot_q, held_slot_d;
  logic [teq_pkg::TIME_W-1:0]   held_time_q, held_time_d;
  logic [teq_pkg::STAT_W-1:0]   ack_stat_q, ack_stat_d;

  // Output register.
  logic                         out_vld_q, out_vld_d;
  logic                         out_fired_q, out_fired_d;
  logic [teq_pkg::ID_W-1:0]     out_slot_q, out_slot_d;
  logic [teq_pkg::TIME_W-1:0]   out_time_q, out_time_d;
  logic [teq_pkg::STAT_W-1:0]   out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;
  logic                         out_load;
  logic                         out_free;

  logic                         req_acc;
  logic                         slot_ok;
  logic                         scan_last;
  logic                         at_cap;

  teq_pkg::teq_slot_cmd_t       cmd;
  teq_pkg::teq_slot_rd_t        rd;

  logic                         a_le_b;
  logic                         a_lt_c;
  logic [teq_pkg::TIME_W-1:0]   add_a;
  logic [teq_pkg::TIME_W-1:0]   add_b;
  logic [teq_pkg::TIME_W-1:0]   sum;

  assign req_i.ready = (state_q == teq_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign slot_ok     = (32'(slot_q) < 32'(teq_pkg::SLOTS));
  assign scan_last   = (scan_q == teq_pkg::SLOT_W'(teq_pkg::SLOTS - 1));
  assign at_cap      = (fires_q == teq_pkg::FIRE_W'(teq_pkg::MAX_FIRES));

  // The adder serves the register request and the periodic re-queue.
  assign add_a = (state_q == teq_pkg::ST_PICK) ? best_time_q : now_q;
  assign add_b = (state_q == teq_pkg::ST_PICK) ?
                 teq_pkg::TIME_W'(rd.pick_period) : teq_pkg::TIME_W'(period_q);

  teq_alu u_alu (
    .cmp_a_i  (rd.scan_time),
    .cmp_b_i  (now_q),
    .cmp_c_i  (best_time_q),
    .add_a_i  (add_a),
    .add_b_i  (add_b),
    .a_le_b_o (a_le_b),
    .a_lt_c_o (a_lt_c),
    .sum_o    (sum)
  );

  teq_slots u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .scan_idx_i (scan_q),
    .pick_idx_i (best_idx_q),
    .ref_idx_i  (teq_pkg::SLOT_W'(slot_q)),
    .rd_o       (rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      teq_pkg::ST_IDLE: begin
        if (req_acc) state_d = teq_pkg::ST_EXEC;
      end
      teq_pkg::ST_EXEC: begin
        if (req_type_q == teq_pkg::REQ_TICK) state_d = teq_pkg::ST_SCAN;
        else state_d = teq_pkg::ST_RESULT;
      end
      teq_pkg::ST_RESULT: begin
        if (out_free) state_d = teq_pkg::ST_IDLE;
      end
      teq_pkg::ST_SCAN: begin
        if (scan_last) state_d = teq_pkg::ST_PICK;
      end
      teq_pkg::ST_PICK: begin
        if (!found_q) begin
          if (out_free) state_d = teq_pkg::ST_IDLE;
        end else if (!rd.pick_armed) begin
          state_d = teq_pkg::ST_SCAN;
        end else if (at_cap) begin
          if (out_free) state_d = teq_pkg::ST_IDLE;
        end else if (!held_q || out_free) begin
          state_d = teq_pkg::ST_SCAN;
        end
      end
      default: state_d = teq_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    req_type_d   = req_type_q;
    slot_d       = slot_q;
    period_d     = period_q;
    once_d       = once_q;
    now_d        = now_q;
    scan_d       = scan_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_time_d  = best_time_q;
    fires_d      = fires_q;
    held_d       = held_q;
    held_slot_d  = held_slot_q;
    held_time_d  = held_time_q;
    ack_stat_d   = ack_stat_q;
    out_load     = 1'b0;
    out_fired_d  = out_fired_q;
    out_slot_d   = out_slot_q;
    out_time_d   = out_time_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    cmd.op       = teq_pkg::SOP_NONE;
    cmd.idx      = teq_pkg::SLOT_W'(slot_q);
    cmd.exp_time = sum;
    cmd.period   = period_q;
    cmd.once     = once_q;

    case (state_q)
      teq_pkg::ST_IDLE: begin
        if (req_acc) begin
          req_type_d = req_i.req_type;
          slot_d     = req_i.slot_id;
          period_d   = req_i.period_us;
          once_d     = req_i.single_shot;
          now_d      = req_i.now_us;
        end
      end
      teq_pkg::ST_EXEC: begin
        ack_stat_d = teq_pkg::STAT_OK;
        case (req_type_q)
          teq_pkg::REQ_REGISTER: begin
            if (slot_ok) begin
              if (!once_q && (period_q == '0)) begin
                ack_stat_d = teq_pkg::STAT_ZERO_PERIOD;
              end else begin
                cmd.op = teq_pkg::SOP_LOAD;
              end
            end
          end
          teq_pkg::REQ_CANCEL: begin
            if (slot_ok && rd.ref_queued) cmd.op = teq_pkg::SOP_DISARM;
          end
          teq_pkg::REQ_TICK: begin
            scan_d  = '0;
            found_d = 1'b0;
            fires_d = '0;
            held_d  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      teq_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_fired_d  = 1'b0;
          out_slot_d   = '0;
          out_time_d   = '0;
          out_status_d = ack_stat_q;
          out_last_d   = 1'b1;
        end
      end
      teq_pkg::ST_SCAN: begin
        // Keep the earliest due slot; a strict compare favors the lower slot.
        if (rd.scan_queued && a_le_b && (!found_q || a_lt_c)) begin
          found_d     = 1'b1;
          best_idx_d  = scan_q;
          best_time_d = rd.scan_time;
        end
        scan_d = scan_q + 1'b1;
      end
      teq_pkg::ST_PICK: begin
        cmd.idx = best_idx_q;
        if (!found_q) begin
          // Nothing more is due: close the tick.
          if (out_free) begin
            out_load     = 1'b1;
            out_fired_d  = held_q;
            out_slot_d   = held_q ? teq_pkg::ID_W'(held_slot_q) : '0;
            out_time_d   = held_q ? held_time_q : '0;
            out_status_d = teq_pkg::STAT_OK;
            out_last_d   = 1'b1;
            held_d       = 1'b0;
          end
        end else if (!rd.pick_armed) begin
          // A cancelled slot reached its expiry and leaves without a result.
          cmd.op  = teq_pkg::SOP_DROP;
          scan_d  = '0;
          found_d = 1'b0;
        end else if (at_cap) begin
          // Firing budget spent while a due slot is still waiting.
          if (out_free) begin
            out_load     = 1'b1;
            out_fired_d  = 1'b1;
            out_slot_d   = teq_pkg::ID_W'(held_slot_q);
            out_time_d   = held_time_q;
            out_status_d = teq_pkg::STAT_CAP;
            out_last_d   = 1'b1;
            held_d       = 1'b0;
          end
        end else if (!held_q || out_free) begin
          if (held_q) begin
            out_load     = 1'b1;
            out_fired_d  = 1'b1;
            out_slot_d   = teq_pkg::ID_W'(held_slot_q);
            out_time_d   = held_time_q;
            out_status_d = teq_pkg::STAT_OK;
            out_last_d   = 1'b0;
          end
          held_d      = 1'b1;
          held_slot_d = best_idx_q;
          held_time_d = best_time_q;
          fires_d     = fires_q + 1'b1;
          cmd.op      = rd.pick_once ? teq_pkg::SOP_RETIRE : teq_pkg::SOP_REQUEUE;
          scan_d      = '0;
          found_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_vld_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= teq_pkg::ST_IDLE;
      found_q   <= 1'b0;
      fires_q   <= '0;
      held_q    <= 1'b0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      found_q   <= found_d;
      fires_q   <= fires_d;
      held_q    <= held_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_type_q   <= req_type_d;
    slot_q       <= slot_d;
    period_q     <= period_d;
    once_q       <= once_d;
    now_q        <= now_d;
    best_idx_q   <= best_idx_d;
    best_time_q  <= best_time_d;
    held_slot_q  <= held_slot_d;
    held_time_q  <= held_time_d;
    ack_stat_q   <= ack_stat_d;
    out_fired_q  <= out_fired_d;
    out_slot_q   <= out_slot_d;
    out_time_q   <= out_time_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.fired        = out_fired_q;
  assign rsp_o.fired_slot   = out_slot_q;
  assign rsp_o.fire_time_us = out_time_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.last         = out_last_q;

  // The output register is never overwritten while its item is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

  // A tick never reports more firings than its budget.
  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= teq_pkg::FIRE_W'(teq_pkg::MAX_FIRES))
    else $error("firing count above cap");

  // A held firing never survives into idle, so no result is lost.
  a_held_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == teq_pkg::ST_IDLE) |-> !held_q)
    else $error("held firing left behind");

  // A result that reports no firing always closes its request.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.fired) |-> rsp_o.last)
    else $error("non-firing result not marked last");

  // Once a request is taken the channel closes until the work is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request channel open while busy");

endmodule

### tb/tb_timer_expiry_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer expiry queue core testbench
// Drives register, cancel, tick and no-operation requests into the core and
// checks every response item against a cycle-free predictor of the timer
// slots, with random idle gaps on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
module tb_timer_expiry_queue_core;
  import teq_pkg::*;

  // One response item as the core reports it.
  typedef struct packed {
    logic                fired;
    logic [ID_W-1:0]     slot;
    logic [TIME_W-1:0]   at;
    logic [STAT_W-1:0]   status;
    logic                last;
  } teq_result_t;

  // Cycles allowed after the last expected item before the run closes. This
  // leaves room for any stray item.
  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned RAND_ITEMS = 208;
  localparam int unsigned MAX_PRINTS = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  teq_req_if req_if ();
  teq_rsp_if rsp_if ();

  timer_expiry_queue_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Predicted slot state. Only queued slots are ever looked at, and a slot is
  // queued only by a register request, so the zero reset here is harmless.
  logic [TIME_W-1:0]   slot_exp    [SLOTS];
  logic [PERIOD_W-1:0] slot_period [SLOTS];
  logic                slot_once   [SLOTS];
  logic                slot_armed  [SLOTS];
  logic                slot_queued [SLOTS];

  // Response items still owed by the core, oldest first.
  teq_result_t outstanding_rsp[$];

  int unsigned err_cnt;
  int unsigned n_items;
  int unsigned n_checked;
  int unsigned n_fires;
  int unsigned n_caps;
  int unsigned n_rejects;
  int unsigned n_silent;

  // When set, the matching side of the channel runs without idle cycles.
  bit src_calm;
  bit snk_calm;

  // Base time of the random part; it moves forward with the ticks.
  logic [TIME_W-1:0] t_now;

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request to the slot state and queues the
  // response items it must produce.
  // --------------------------------------------------------------------------
  task automatic compute_response(input teq_req_e kind, input logic [ID_W-1:0] sid,
                                  input logic [PERIOD_W-1:0] per, input logic once,
                                  input logic [TIME_W-1:0] now);
    teq_result_t batch[$];
    teq_result_t ack;
    int          best;
    int          fires;
    bit          capped;

    ack    = '{1'b0, '0, '0, STAT_OK, 1'b1};
    fires  = 0;
    capped = 1'b0;
    case (kind)
      REQ_REGISTER: begin
        if (int'(sid) < SLOTS) begin
          if (!once && per == '0) begin
            // A periodic timer with no period would never leave the queue.
            ack.status = STAT_ZERO_PERIOD;
            n_rejects++;
          end else begin
            slot_exp[sid]    = now + TIME_W'(per);
            slot_period[sid] = per;
            slot_once[sid]   = once;
            slot_armed[sid]  = 1'b1;
            slot_queued[sid] = 1'b1;
          end
        end
      end
      REQ_CANCEL: begin
        if (int'(sid) < SLOTS && slot_queued[sid]) begin
          slot_armed[sid] = 1'b0;
        end
      end
      REQ_TICK: begin
        forever begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_queued[i] && slot_exp[i] <= now) begin
              if (best < 0 || slot_exp[i] < slot_exp[best]) begin
                best = i;
              end
            end
          end
          if (best < 0) break;
          if (!slot_armed[best]) begin
            // Cancelled slots drop out without a response item.
            slot_queued[best] = 1'b0;
            n_silent++;
            continue;
          end
          if (fires >= MAX_FIRES) begin
            capped = 1'b1;
            break;
          end
          batch.push_back('{1'b1, ID_W'(best), slot_exp[best], STAT_OK, 1'b0});
          fires++;
          if (slot_once[best]) begin
            slot_armed[best]  = 1'b0;
            slot_queued[best] = 1'b0;
          end else begin
            slot_exp[best] = slot_exp[best] + TIME_W'(slot_period[best]);
          end
        end
      end
      default: ;
    endcase

    if (batch.size() == 0) begin
      outstanding_rsp.push_back(ack);
    end else begin
      batch[batch.size()-1].last = 1'b1;
      if (capped) begin
        batch[batch.size()-1].status = STAT_CAP;
        n_caps++;
      end
      n_fires += batch.size();
      foreach (batch[i]) outstanding_rsp.push_back(batch[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle lengths: most gaps are short, some are long.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Every call starts and ends on a rising edge; valid stays
  // high between back-to-back items and is lowered only for a gap.
  // --------------------------------------------------------------------------
  task automatic send_item(input teq_req_e kind, input logic [ID_W-1:0] sid,
                           input logic [PERIOD_W-1:0] per, input logic once,
                           input logic [TIME_W-1:0] now);
    int unsigned gap;

    gap = (!src_calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.slot_id     <= sid;
    req_if.period_us   <= per;
    req_if.single_shot <= once;
    req_if.now_us      <= now;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    compute_response(kind, sid, per, once, now);
    n_items++;
  endtask

  // Holds the request side idle until every owed response item has arrived.
  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding_rsp.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready drops for random stretches unless the sink is calm.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;

    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!snk_calm && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  // Each accepted response item is matched against the oldest expectation.
  always @(posedge clk_i) begin : rsp_check
    teq_result_t want;

    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_checked++;
      if (outstanding_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected item: fired %0b slot %0d time 0x%0h",
                                  rsp_if.fired, rsp_if.fired_slot, rsp_if.fire_time_us));
      end else begin
        want = outstanding_rsp.pop_front();
        check_field("fired", rsp_if.fired, want.fired);
        check_field("fired_slot", rsp_if.fired_slot, want.slot);
        check_field("fire_time_us", rsp_if.fire_time_us, want.at);
        check_field("status", rsp_if.status, want.status);
        check_field("last", rsp_if.last, want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Requests that fire nothing answer with a single plain acknowledge.
  task automatic test_acknowledge();
    send_item(REQ_NOP, 4'd0, '0, 1'b0, '0);
    send_item(REQ_CANCEL, 4'd5, '0, 1'b0, '0);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, '0);
  endtask

  // A periodic timer with period zero is refused; a one-shot one is fine and
  // fires on the very tick that matches its registration time.
  task automatic test_zero_period();
    send_item(REQ_REGISTER, 4'd3, '0, 1'b0, 48'd100);
    send_item(REQ_REGISTER, 4'd3, '0, 1'b1, 48'd100);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'd100);
  endtask

  // Firing order by expiry with ties to the lower slot, periodic catch-up,
  // silent leave of a cancelled slot, and re-arming a cancelled slot that is
  // still queued by registering it again.
  task automatic test_order_and_cancel();
    send_item(REQ_REGISTER, 4'd9, 32'd50, 1'b1, 48'd1000);
    send_item(REQ_REGISTER, 4'd2, 32'd50, 1'b1, 48'd1000);
    send_item(REQ_REGISTER, 4'd7, 32'd20, 1'b0, 48'd1000);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'd1060);
    send_item(REQ_CANCEL, 4'd7, '0, 1'b0, '0);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'd2000);
    send_item(REQ_REGISTER, 4'd4, 32'd10, 1'b0, 48'd3000);
    send_item(REQ_CANCEL, 4'd4, '0, 1'b0, '0);
    send_item(REQ_REGISTER, 4'd4, 32'd5, 1'b1, 48'd3000);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'd3020);
  endtask

  // Expiry sums wrap at the top of the time range.
  task automatic test_time_wrap();
    send_item(REQ_REGISTER, 4'd0, '1, 1'b1, '1);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'h0000_FFFF_FFFF);
  endtask

  // A period-one timer far behind the tick hits the firing cap; the slot is
  // then cancelled and flushed with a tick at the end of time.
  task automatic test_fire_cap();
    send_item(REQ_REGISTER, 4'd15, 32'd1, 1'b0, 48'd5000);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, 48'd6000);
    send_item(REQ_CANCEL, 4'd15, '0, 1'b0, '0);
    send_item(REQ_TICK, 4'd0, '0, 1'b0, '1);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Time moves forward in small steps so that registered
  // timers really expire, most registrations use periods near the tick step,
  // and a share of items is noise: past ticks, odd fields, zero periods and
  // one-shot timers at arbitrary times.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic();
    int unsigned       pick;
    teq_req_e          kind;
    logic [ID_W-1:0]   sid;
    logic [PERIOD_W-1:0] per;
    logic              once;
    logic [TIME_W-1:0] now;

    t_now = {16'($urandom_range(0, 16'hFFF0)), 32'($urandom)};
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 30 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      sid  = ID_W'($urandom_range(0, SLOTS - 1));
      once = 1'($urandom_range(0, 1));
      per  = PERIOD_W'($urandom);
      now  = t_now;
      if (pick < 35) begin
        kind = REQ_REGISTER;
        case ($urandom_range(0, 19))
          0:       per = '0;
          1, 2:    per = PERIOD_W'($urandom);
          default: per = once ? PERIOD_W'($urandom_range(0, 300))
                              : PERIOD_W'($urandom_range(20, 300));
        endcase
      end else if (pick < 50) begin
        kind = REQ_CANCEL;
      end else if (pick < 85) begin
        kind  = REQ_TICK;
        t_now = t_now + TIME_W'($urandom_range(0, 120));
        now   = t_now;
      end else if (pick < 90) begin
        kind = REQ_TICK;
        now  = t_now - TIME_W'($urandom_range(0, 200));
      end else if (pick < 95) begin
        kind = REQ_NOP;
        now  = {16'($urandom), 32'($urandom)};
      end else begin
        // A one-shot timer anywhere in time: it fires once at most.
        kind = REQ_REGISTER;
        once = 1'b1;
        now  = {16'($urandom), 32'($urandom)};
      end
      send_item(kind, sid, per, once, now);
      if ($urandom_range(0, 99) < 3) wait_all_results();
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    err_cnt   = 0;
    n_items   = 0;
    n_checked = 0;
    n_fires   = 0;
    n_caps    = 0;
    n_rejects = 0;
    n_silent  = 0;
    src_calm  = 1'b0;
    snk_calm  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_exp[i]    = '0;
      slot_period[i] = '0;
      slot_once[i]   = 1'b0;
      slot_armed[i]  = 1'b0;
      slot_queued[i] = 1'b0;
    end
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_NOP;
    req_if.slot_id     <= '0;
    req_if.period_us   <= '0;
    req_if.single_shot <= 1'b0;
    req_if.now_us      <= '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_acknowledge();
    test_zero_period();
    test_order_and_cancel();
    test_time_wrap();
    test_fire_cap();
    // The random part starts from a quiet core with all slots free.
    wait_all_results();
    test_random_traffic();
    wait_all_results();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Covered %0d requests and %0d response items: %0d firings, %0d capped ticks,",
             n_items, n_checked, n_fires, n_caps);
    $display("%0d zero-period rejections and %0d cancelled slots flushed silently.",
             n_rejects, n_silent);
    if (err_cnt == 0 && outstanding_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d items still owed", err_cnt, outstanding_rsp.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #50ms;
    $display("Timeout with %0d items still owed", outstanding_rsp.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
